@@ rtl/core/hpe_pkg.sv @@
// Shared types and constants for the heartbeat pulse envelope core.
`timescale 1ns / 1ps
`default_nettype none

package hpe_pkg;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_START  = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_RATE_DIV  = 7'b0000010,
        ST_SHAPE     = 7'b0000100,
        ST_PHASE_DIV = 7'b0001000,
        ST_SCALE     = 7'b0010000,
        ST_LEVEL_DIV = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

    localparam int unsigned BPM_W      = 16;
    localparam int unsigned IVL_W      = 11;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned NUM_W      = 16;

    localparam logic [BPM_W-1:0]   BPM_RESET     = 16'd60;
    localparam logic [BPM_W-1:0]   RATE_MIN      = 16'd30;
    localparam logic [BPM_W-1:0]   RATE_MAX      = 16'd240;
    localparam logic [NUM_W-1:0]   MS_PER_MINUTE = 16'd60000;
    localparam logic [IVL_W-1:0]   ATTACK_CAP    = 11'd40;
    localparam logic [IVL_W-1:0]   DECAY_CAP     = 11'd180;
    // x / 5 == (x * 6554) >> 15 for every x below 8192
    localparam logic [12:0]        RECIP_5       = 13'd6554;
    localparam int unsigned        RECIP_SHIFT   = 15;

endpackage : hpe_pkg

`default_nettype wire

@@ rtl/core/heartbeat_pulse_envelope_core.sv @@
// Heartbeat pulse envelope core: command sequencer around one shared restoring divider.
`timescale 1ns / 1ps
`default_nettype none

// One result beat per input beat. All divisions but those by five (a reciprocal
// multiply) go through a single restoring divider that retires one quotient bit
// per cycle. A start runs 16 divider steps for 60000 / bpm, then the shape and
// finish states. A sample while running runs TIME_BITS steps for the phase modulo
// and the scale state, then 16 steps for the level scaling when the phase lies
// inside the pulse, then finish. Stop, rejected start, unused mode and idle
// samples go straight to finish. s_ready is low while an item is in work; a
// finished result waits in the output register, and the next result holds until it
// drains. A write on cfg_we updates the beat rate used by later starts.
module heartbeat_pulse_envelope_core
    import hpe_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_we,
    input  wire logic [BPM_W-1:0]    cfg_wdata,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_mode,
    input  wire logic [NOW_W-1:0]    s_now_ms,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [LEVEL_W-1:0]       m_level,
    output logic                     m_is_active,
    output logic                     m_start_ok
);

    localparam int unsigned CNT_W = $clog2(TIME_BITS + 1);
    localparam int unsigned PAD   = TIME_BITS - NUM_W;

    state_t                 state_reg,    state_next;
    logic [BPM_W-1:0]       bpm_reg;
    logic [IVL_W-1:0]       interval_reg, interval_next;
    logic [NOW_W-1:0]       start_reg,    start_next;
    logic                   running_reg,  running_next;
    logic [IVL_W-1:0]       attack_reg,   attack_next;
    logic [IVL_W-1:0]       decay_reg,    decay_next;
    logic [NOW_W-1:0]       now_reg,      now_next;
    logic [LEVEL_W-1:0]     level_reg,    level_next;
    logic                   ok_reg,       ok_next;

    logic [TIME_BITS-1:0]   quo_reg,      quo_next;
    logic [IVL_W-1:0]       rem_reg,      rem_next;
    logic [IVL_W-1:0]       dvsr_reg,     dvsr_next;
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;

    logic                   m_valid_reg,  m_valid_next;
    logic [LEVEL_W-1:0]     m_level_reg,  m_level_next;
    logic                   m_active_reg, m_active_next;
    logic                   m_ok_reg,     m_ok_next;

    logic [IVL_W:0]         trial;
    logic                   trial_ge;
    logic [IVL_W-1:0]       rem_step;
    logic [TIME_BITS-1:0]   quo_step;
    logic                   last_step;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   rate_ok;
    logic [23:0]            att_prod;
    logic [25:0]            dec_prod;
    logic [IVL_W-1:0]       att_raw;
    logic [IVL_W-1:0]       dec_raw;
    logic [IVL_W:0]         pulse;
    logic [IVL_W:0]         pulse_left;
    logic [IVL_W+LEVEL_W:0] rise_num;
    logic [IVL_W+LEVEL_W:0] fall_num;

    // shared divider step
    assign trial     = {rem_reg, quo_reg[TIME_BITS-1]};
    assign trial_ge  = trial >= {1'b0, dvsr_reg};
    assign rem_step  = trial_ge ? IVL_W'(trial - {1'b0, dvsr_reg}) : IVL_W'(trial);
    assign quo_step  = {quo_reg[TIME_BITS-2:0], trial_ge};
    assign last_step = cnt_reg == CNT_W'(1);

    assign elapsed   = TIME_BITS'(s_now_ms) - TIME_BITS'(start_reg);
    assign rate_ok   = (bpm_reg >= RATE_MIN) && (bpm_reg <= RATE_MAX);

    assign att_prod  = 24'(interval_reg) * 24'(RECIP_5);
    assign dec_prod  = (26'({interval_reg, 1'b0}) + 26'(interval_reg)) * 26'(RECIP_5);
    assign att_raw   = IVL_W'(att_prod >> RECIP_SHIFT);
    assign dec_raw   = IVL_W'(dec_prod >> RECIP_SHIFT);

    assign pulse      = {1'b0, attack_reg} + {1'b0, decay_reg};
    assign pulse_left = pulse - {1'b0, rem_reg};
    assign rise_num   = ({rem_reg, 8'd0} - (IVL_W+LEVEL_W+1)'(rem_reg));
    assign fall_num   = ({pulse_left, 8'd0} - (IVL_W+LEVEL_W+1)'(pulse_left));

    always_comb begin
        state_next    = state_reg;
        interval_next = interval_reg;
        start_next    = start_reg;
        running_next  = running_reg;
        attack_next   = attack_reg;
        decay_next    = decay_reg;
        now_next      = now_reg;
        level_next    = level_reg;
        ok_next       = ok_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dvsr_next     = dvsr_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        m_level_next  = m_level_reg;
        m_active_next = m_active_reg;
        m_ok_next     = m_ok_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next   = s_now_ms;
                    level_next = '0;
                    ok_next    = 1'b0;
                    rem_next   = '0;
                    state_next = ST_FINISH;
                    case (mode_t'(s_mode))
                        MODE_SAMPLE: begin
                            if (running_reg && (interval_reg != '0)) begin
                                quo_next   = elapsed;
                                dvsr_next  = interval_reg;
                                cnt_next   = CNT_W'(TIME_BITS);
                                state_next = ST_PHASE_DIV;
                            end
                        end
                        MODE_START: begin
                            if (rate_ok) begin
                                quo_next   = TIME_BITS'(MS_PER_MINUTE) << PAD;
                                dvsr_next  = IVL_W'(bpm_reg);
                                cnt_next   = CNT_W'(NUM_W);
                                state_next = ST_RATE_DIV;
                            end else begin
                                interval_next = '0;
                                running_next  = 1'b0;
                            end
                        end
                        MODE_STOP: begin
                            interval_next = '0;
                            running_next  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RATE_DIV: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step) begin
                    interval_next = quo_step[IVL_W-1:0];
                    start_next    = now_reg;
                    running_next  = 1'b1;
                    ok_next       = 1'b1;
                    state_next    = ST_SHAPE;
                end
            end
            ST_SHAPE: begin
                attack_next = (att_raw < ATTACK_CAP) ? att_raw : ATTACK_CAP;
                if (attack_next == '0) begin
                    attack_next = IVL_W'(1);
                end
                decay_next = (dec_raw < DECAY_CAP) ? dec_raw : DECAY_CAP;
                state_next = ST_FINISH;
            end
            ST_PHASE_DIV: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                rem_next   = '0;
                cnt_next   = CNT_W'(NUM_W);
                state_next = ST_LEVEL_DIV;
                if (rem_reg < attack_reg) begin
                    quo_next  = TIME_BITS'(NUM_W'(rise_num)) << PAD;
                    dvsr_next = attack_reg;
                end else if (({1'b0, rem_reg} < pulse) && (decay_reg != '0)) begin
                    quo_next  = TIME_BITS'(NUM_W'(fall_num)) << PAD;
                    dvsr_next = decay_reg;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_LEVEL_DIV: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_step) begin
                    level_next = quo_step[LEVEL_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_level_next  = level_reg;
                    m_active_next = running_reg && (interval_reg != '0);
                    m_ok_next     = ok_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bpm_reg      <= BPM_RESET;
            interval_reg <= '0;
            start_reg    <= '0;
            running_reg  <= 1'b0;
            attack_reg   <= IVL_W'(1);
            decay_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                bpm_reg <= cfg_wdata;
            end
            interval_reg <= interval_next;
            start_reg    <= start_next;
            running_reg  <= running_next;
            attack_reg   <= attack_next;
            decay_reg    <= decay_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        level_reg    <= level_next;
        ok_reg       <= ok_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvsr_reg     <= dvsr_next;
        cnt_reg      <= cnt_next;
        m_level_reg  <= m_level_next;
        m_active_reg <= m_active_next;
        m_ok_reg     <= m_ok_next;
    end

    assign s_ready     = state_reg == ST_IDLE;
    assign m_valid     = m_valid_reg;
    assign m_level     = m_level_reg;
    assign m_is_active = m_active_reg;
    assign m_start_ok  = m_ok_reg;

    a_running_has_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (interval_reg != '0))
        else $error("running without a beat interval");

    a_attack_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE) |-> (attack_reg != '0))
        else $error("zero attack divisor in level scaling");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready while a beat is in work");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat raised outside finish");

    a_start_ok_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ok_reg) |-> m_active_reg)
        else $error("accepted start reported inactive");

endmodule : heartbeat_pulse_envelope_core

`default_nettype wire

@@ tb/sv/heartbeat_pulse_envelope_core_tb.sv @@
// Testbench for the heartbeat pulse envelope core: directed and random command streams.
`timescale 1ns / 1ps

module heartbeat_pulse_envelope_core_tb;

    import hpe_pkg::*;

    localparam int unsigned RUN_LIMIT   = 600000;
    localparam int unsigned SETTLE_WAIT = 80;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               active;
        logic               ok;
    } pulse_result_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [BPM_W-1:0]    cfg_wdata   = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [1:0]          s_mode      = MODE_SAMPLE;
    logic [NOW_W-1:0]    s_now_ms    = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [LEVEL_W-1:0]  m_level;
    logic                m_is_active;
    logic                m_start_ok;

    // predictor state
    logic [BPM_W-1:0]    rate_bpm     = BPM_RESET;
    logic [IVL_W-1:0]    beat_ivl     = '0;
    logic [NOW_W-1:0]    beat_t0      = '0;
    logic                beat_running = 1'b0;

    pulse_result_t       pulse_due[$];
    int unsigned         err_count   = 0;
    int unsigned         cycle_count = 0;
    int unsigned         burst_left  = 0;
    logic [7:0]          ready_tick  = '0;
    logic [1:0]          ready_style = 2'd0;

    heartbeat_pulse_envelope_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level     (m_level),
        .m_is_active (m_is_active),
        .m_start_ok  (m_start_ok)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("heartbeat_pulse_envelope_core_tb: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        ready_tick <= ready_tick + 8'd1;
        if (ready_tick[5:0] == 6'd0) begin
            ready_style <= 2'($urandom_range(0, 3));
        end
        case (ready_style)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= (ready_tick[2:0] == 3'd0);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic logic [LEVEL_W-1:0] envelope_level(logic [NOW_W-1:0] t);
        logic [31:0] ivl;
        logic [31:0] phase;
        logic [31:0] attack;
        logic [31:0] decay;
        logic [31:0] pulse;
        if (!beat_running || beat_ivl == '0) begin
            return '0;
        end
        ivl = 32'(beat_ivl);
        phase = (t - beat_t0) % ivl;
        attack = (ivl / 5 < 32'(ATTACK_CAP)) ? ivl / 5 : 32'(ATTACK_CAP);
        if (attack == 0) begin
            attack = 1;
        end
        decay = ((ivl * 3) / 5 < 32'(DECAY_CAP)) ? (ivl * 3) / 5 : 32'(DECAY_CAP);
        pulse = attack + decay;
        if (phase < attack) begin
            return LEVEL_W'((phase * 255) / attack);
        end
        if (phase < pulse && decay > 0) begin
            return LEVEL_W'(((pulse - phase) * 255) / decay);
        end
        return '0;
    endfunction

    function automatic pulse_result_t predict_pulse(mode_t m, logic [NOW_W-1:0] t);
        pulse_result_t r;
        r.level = '0;
        r.ok = 1'b0;
        case (m)
            MODE_SAMPLE: r.level = envelope_level(t);
            MODE_START: begin
                if (rate_bpm >= RATE_MIN && rate_bpm <= RATE_MAX) begin
                    beat_ivl = IVL_W'(32'(MS_PER_MINUTE) / 32'(rate_bpm));
                    beat_t0 = t;
                    beat_running = 1'b1;
                    r.ok = 1'b1;
                end else begin
                    beat_ivl = '0;
                    beat_running = 1'b0;
                end
            end
            MODE_STOP: begin
                beat_ivl = '0;
                beat_running = 1'b0;
            end
            default: ;
        endcase
        r.active = beat_running && (beat_ivl != '0);
        return r;
    endfunction

    always @(posedge aclk) begin
        pulse_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pulse_due.size() == 0) begin
                $error("result beat with nothing expected: level %0d", m_level);
                err_count++;
            end else begin
                exp_r = pulse_due.pop_front();
                if (m_level !== exp_r.level) begin
                    $error("level expected %0d actual %0d", exp_r.level, m_level);
                    err_count++;
                end
                if (m_is_active !== exp_r.active) begin
                    $error("is_active expected %0b actual %0b", exp_r.active, m_is_active);
                    err_count++;
                end
                if (m_start_ok !== exp_r.ok) begin
                    $error("start_ok expected %0b actual %0b", exp_r.ok, m_start_ok);
                    err_count++;
                end
            end
        end
    end

    task automatic send_cmd(input mode_t m, input logic [NOW_W-1:0] t);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 4))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        s_valid  <= 1'b1;
        s_mode   <= m;
        s_now_ms <= t;
        do @(posedge aclk); while (!s_ready);
        pulse_due.push_back(predict_pulse(m, t));
        burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        if (burst_left != 0) begin
            s_valid <= 1'b0;
            burst_left = 0;
        end
        while (pulse_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_rate(input logic [BPM_W-1:0] v);
        drain();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        rate_bpm = v;
    endtask

    task automatic test_default_rate();
        send_cmd(MODE_SAMPLE, 32'd0);
        send_cmd(MODE_NONE, 32'hFFFF_FFFF);
        send_cmd(MODE_STOP, 32'd5);
        send_cmd(MODE_START, 32'd1000);
        send_cmd(MODE_SAMPLE, 32'd1000);
        send_cmd(MODE_SAMPLE, 32'd1020);
        send_cmd(MODE_SAMPLE, 32'd1040);
        send_cmd(MODE_SAMPLE, 32'd1130);
        send_cmd(MODE_SAMPLE, 32'd1220);
        send_cmd(MODE_SAMPLE, 32'd2000);
        send_cmd(MODE_NONE, 32'd2010);
    endtask

    task automatic test_time_wrap();
        send_cmd(MODE_START, 32'hFFFF_FFF0);
        send_cmd(MODE_SAMPLE, 32'h0000_0010);
        send_cmd(MODE_SAMPLE, 32'hFFFF_FFFF);
        send_cmd(MODE_START, 32'd0);
        send_cmd(MODE_SAMPLE, 32'd0);
    endtask

    task automatic test_rate_limits();
        write_rate(RATE_MAX);
        send_cmd(MODE_START, 32'd500);
        send_cmd(MODE_SAMPLE, 32'd540);
        send_cmd(MODE_SAMPLE, 32'd689);
        write_rate(RATE_MIN);
        send_cmd(MODE_START, 32'd7);
        send_cmd(MODE_SAMPLE, 32'd2006);
        write_rate(RATE_MIN - 16'd1);
        send_cmd(MODE_START, 32'd9);
        send_cmd(MODE_SAMPLE, 32'd30);
        write_rate(RATE_MAX + 16'd1);
        send_cmd(MODE_START, 32'd11);
        write_rate(16'd0);
        send_cmd(MODE_START, 32'd13);
        write_rate(16'hFFFF);
        send_cmd(MODE_START, 32'd15);
        write_rate(BPM_RESET);
    endtask

    task automatic test_random_beats();
        int unsigned pick;
        logic [BPM_W-1:0] rate;
        logic [NOW_W-1:0] t;
        mode_t m;
        for (int ph = 0; ph < 9; ph++) begin
            if (ph % 4 == 3) begin
                rate = ($urandom_range(0, 1) == 0) ? BPM_W'($urandom_range(0, 29))
                                                   : BPM_W'($urandom_range(241, 65535));
            end else begin
                rate = BPM_W'($urandom_range(30, 240));
            end
            write_rate(rate);
            send_cmd(MODE_START, $urandom());
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                t = beat_t0 + $urandom_range(0, 4500);
                if (pick < 66) begin
                    m = MODE_SAMPLE;
                end else if (pick < 74) begin
                    m = MODE_SAMPLE;
                    t = $urandom();
                end else if (pick < 86) begin
                    m = MODE_START;
                    if (pick < 78) begin
                        t = $urandom();
                    end
                end else if (pick < 93) begin
                    m = MODE_STOP;
                end else begin
                    m = MODE_NONE;
                    t = $urandom();
                end
                send_cmd(m, t);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_rate();
        test_time_wrap();
        test_rate_limits();
        test_random_beats();
        drain();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("heartbeat_pulse_envelope_core_tb: clean");
        end else begin
            $display("heartbeat_pulse_envelope_core_tb: errors");
        end
        $finish;
    end

endmodule
